// ===== hdl/rle_cell_pattern_decoder_top_macros.svh =====
// Assertion macros used by the checker file.
`ifndef RLE_CELL_PATTERN_DECODER_TOP_MACROS_SVH
`define RLE_CELL_PATTERN_DECODER_TOP_MACROS_SVH

// antecedent holds -> consequent holds in the same cycle
`define RCPD_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("rcpd assertion failed");

// antecedent holds -> consequent holds in the next cycle
`define RCPD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("rcpd assertion failed");

`endif

// ===== hdl/rcpd_pkg.sv =====
`default_nettype none

package rcpd_pkg;

	localparam logic [7:0] CH_ZERO = 8'h30;
	localparam logic [7:0] CH_NINE = 8'h39;
	localparam logic [7:0] CH_LIVE = 8'h6f;  // 'o'
	localparam logic [7:0] CH_DEAD = 8'h62;  // 'b'
	localparam logic [7:0] CH_ROW  = 8'h24;  // '$'
	localparam logic [7:0] CH_END  = 8'h21;  // '!'

	localparam logic [15:0] ROW_WIDTH_RST = 16'd64;
	localparam logic [15:0] RUN_MAX_OUT   = 16'hffff;

	typedef enum logic [2:0] {
		SYM_DIGIT,
		SYM_LIVE,
		SYM_DEAD,
		SYM_ROW,
		SYM_END,
		SYM_OTHER
	} sym_class_t;

	typedef struct packed {
		logic        row_overflow;
		logic        pattern_end;
		logic        row_end;
		logic [15:0] run_length;
		logic        cell_value;
	} result_t;

	function automatic sym_class_t classify(input logic [7:0] s);
		sym_class_t c;
		case (s) inside
			[CH_ZERO:CH_NINE]: c = SYM_DIGIT;
			CH_LIVE:           c = SYM_LIVE;
			CH_DEAD:           c = SYM_DEAD;
			CH_ROW:            c = SYM_ROW;
			CH_END:            c = SYM_END;
			default:           c = SYM_OTHER;
		endcase
		return c;
	endfunction

endpackage

`default_nettype wire

// ===== hdl/rcpd_core.sv =====
`default_nettype none

module rcpd_core import rcpd_pkg::*; #(
	parameter int COUNT_BITS = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic [15:0] row_width,
	input  wire logic        fire,
	input  wire logic [7:0]  symbol,
	output logic             res_valid,
	output result_t          res
);

	localparam int WW = (COUNT_BITS > 16) ? COUNT_BITS : 16;
	localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

	logic [COUNT_BITS-1:0] run_count_q;
	logic [15:0]           cells_left_q;
	logic                  overflow_seen_q;

	sym_class_t            cls;
	logic [COUNT_BITS+3:0] ext, prod;
	logic [COUNT_BITS-1:0] count_d, n;
	logic [WW-1:0]         n_w, left_w;
	logic                  over;
	logic [15:0]           left_d;
	logic                  ovf_d;

	assign cls = classify(symbol);

	// count * 10 + digit, saturating
	assign ext  = {4'd0, run_count_q};
	assign prod = (ext << 3) + (ext << 1) + (COUNT_BITS+4)'(4'(symbol - CH_ZERO));

	assign n      = (run_count_q == '0) ? COUNT_BITS'(1) : run_count_q;
	assign n_w    = WW'(n);
	assign left_w = WW'(cells_left_q);
	assign over   = n_w > left_w;

	always_comb begin
		count_d   = run_count_q;
		left_d    = cells_left_q;
		ovf_d     = overflow_seen_q;
		res_valid = 1'b0;
		res       = '0;
		case (cls)
			SYM_DIGIT: begin
				count_d = (prod[COUNT_BITS+3:COUNT_BITS] != 4'd0) ?
					COUNT_MAX : prod[COUNT_BITS-1:0];
			end
			SYM_LIVE, SYM_DEAD: begin
				count_d   = '0;
				left_d    = over ? 16'd0 : 16'(left_w - n_w);
				ovf_d     = overflow_seen_q | over;
				res_valid = 1'b1;
				res.cell_value   = (cls == SYM_LIVE);
				res.run_length   = (n_w > WW'(RUN_MAX_OUT)) ? RUN_MAX_OUT : n_w[15:0];
				res.row_overflow = overflow_seen_q | over;
			end
			SYM_ROW, SYM_END: begin
				count_d   = '0;
				left_d    = row_width;
				ovf_d     = 1'b0;
				res_valid = 1'b1;
				res.run_length   = cells_left_q;
				res.row_end      = 1'b1;
				res.pattern_end  = (cls == SYM_END);
				res.row_overflow = overflow_seen_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_count_q     <= '0;
			cells_left_q    <= ROW_WIDTH_RST;
			overflow_seen_q <= 1'b0;
		end else if (fire) begin
			run_count_q     <= count_d;
			cells_left_q    <= left_d;
			overflow_seen_q <= ovf_d;
		end
	end

endmodule

`default_nettype wire

// ===== hdl/rcpd_out_reg.sv =====
`default_nettype none

module rcpd_out_reg import rcpd_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        load,
	input  wire result_t     res,
	output logic             can_load,
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [15:0]      m_axis_tdata,
	output logic             m_axis_tlast,
	output logic [2:0]       m_axis_tuser
);

	logic    valid_s2;
	result_t result_s2;

	assign can_load = !valid_s2 || m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (can_load) begin
			valid_s2 <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (can_load && load) begin
			result_s2 <= res;
		end
	end

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tdata  = result_s2.run_length;
	assign m_axis_tlast  = result_s2.row_end;
	assign m_axis_tuser  = {result_s2.row_overflow, result_s2.pattern_end,
		result_s2.cell_value};

endmodule

`default_nettype wire

// ===== hdl/rle_cell_pattern_decoder_top.sv =====
// Channel   Dir  Signals                          Content
// s_axis    in   tvalid tready tdata[7:0]         one pattern character per word
// m_axis    out  tvalid tready tdata tlast tuser  one run per word
// cfg       in   valid ready data[15:0]           row width
//
// One character per cycle when not stalled: input register, one pass of count/row
// update, result register. A word goes valid as its character leaves the input register.
// Reset: count 0, row width 64, cells left 64, no words held.
// A stalled result holds the input register only when the held character yields a run;
// digits and ignored characters keep flowing.
`default_nettype none

module rle_cell_pattern_decoder_top import rcpd_pkg::*; #(
	parameter int COUNT_BITS = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [7:0]  s_axis_tdata,   // [7:0] symbol
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [15:0]      m_axis_tdata,   // [15:0] run_length
	output logic             m_axis_tlast,   // row_end
	output logic [2:0]       m_axis_tuser,   // [0] cell_value [1] pattern_end [2] row_overflow
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [15:0] cfg_data
);

	logic        valid_s1;
	logic [7:0]  symbol_s1;
	logic [15:0] row_width_q;
	logic        res_valid, can_load, advance;
	result_t     res;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_width_q <= ROW_WIDTH_RST;
		end else if (cfg_valid) begin
			row_width_q <= cfg_data;
		end
	end

	assign advance       = valid_s1 && (!res_valid || can_load);
	assign s_axis_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			symbol_s1 <= s_axis_tdata;
		end
	end

	rcpd_core #(
		.COUNT_BITS(COUNT_BITS)
	) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.row_width (row_width_q),
		.fire      (advance),
		.symbol    (symbol_s1),
		.res_valid (res_valid),
		.res       (res)
	);

	rcpd_out_reg u_out (
		.clk           (clk),
		.arst_n        (arst_n),
		.load          (advance && res_valid),
		.res           (res),
		.can_load      (can_load),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.m_axis_tuser  (m_axis_tuser)
	);

endmodule

`default_nettype wire

// ===== hdl/rcpd_checker.sv =====
`default_nettype none
`include "rle_cell_pattern_decoder_top_macros.svh"

module rcpd_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        m_axis_tvalid,
	input wire logic        m_axis_tready,
	input wire logic [15:0] m_axis_tdata,
	input wire logic        m_axis_tlast,
	input wire logic [2:0]  m_axis_tuser
);

	// stalled word stays put
	`RCPD_ASSERT_NEXT(a_hold, clk, arst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast) && $stable(m_axis_tuser))

	// pattern end only on a row-closing fill
	`RCPD_ASSERT_IMP(a_pend_row, clk, arst_n, m_axis_tvalid && m_axis_tuser[1], m_axis_tlast)

	// fills are always dead
	`RCPD_ASSERT_IMP(a_fill_dead, clk, arst_n, m_axis_tvalid && m_axis_tlast, !m_axis_tuser[0])

	// live/dead runs are never empty
	`RCPD_ASSERT_IMP(a_run_nonzero, clk, arst_n, m_axis_tvalid && !m_axis_tlast, m_axis_tdata != 16'd0)

endmodule

bind rle_cell_pattern_decoder_top rcpd_checker u_chk (
	.clk           (clk),
	.arst_n        (arst_n),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tlast  (m_axis_tlast),
	.m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire

// ===== test/rle_cell_pattern_decoder_top_tb.sv =====
`timescale 1ns / 1ps
`default_nettype none

module rle_cell_pattern_decoder_top_tb;
	import rcpd_pkg::*;

	localparam int COUNT_BITS   = 16;
	localparam int CYCLE_LIMIT  = 200000;
	localparam int DRAIN_CYCLES = 8;

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata;   // [7:0] symbol
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [15:0] m_axis_tdata;   // [15:0] run_length
	logic        m_axis_tlast;   // row_end
	logic [2:0]  m_axis_tuser;   // [0] cell_value [1] pattern_end [2] row_overflow
	logic        cfg_valid;
	logic        cfg_ready;
	logic [15:0] cfg_data;

	class run_scoreboard;
		logic [15:0]           row_width;
		logic [15:0]           cells_left;
		logic [COUNT_BITS-1:0] run_count;
		bit                    overflow_seen;
		result_t               pending_runs[$];
		int                    errors;

		function new();
			row_width     = ROW_WIDTH_RST;
			cells_left    = ROW_WIDTH_RST;
			run_count     = '0;
			overflow_seen = 1'b0;
			errors        = 0;
		endfunction

		// new width only applies at the next row reload
		function void set_width(logic [15:0] w);
			row_width = w;
		endfunction

		function void note_symbol(logic [7:0] sym);
			logic [63:0] next_count;
			logic [63:0] n;
			result_t     r;
			r = '0;
			if (sym >= CH_ZERO && sym <= CH_NINE) begin
				next_count = 64'(run_count) * 10 + 64'(sym - CH_ZERO);
				if (next_count > 64'({COUNT_BITS{1'b1}}))
					run_count = {COUNT_BITS{1'b1}};
				else
					run_count = next_count[COUNT_BITS-1:0];
			end else if (sym == CH_LIVE || sym == CH_DEAD) begin
				n = (run_count == 0) ? 64'd1 : 64'(run_count);
				run_count = '0;
				if (n > 64'(cells_left)) begin
					cells_left    = '0;
					overflow_seen = 1'b1;
				end else begin
					cells_left = cells_left - n[15:0];
				end
				r.cell_value   = (sym == CH_LIVE);
				r.run_length   = (n > 64'(RUN_MAX_OUT)) ? RUN_MAX_OUT : n[15:0];
				r.row_overflow = overflow_seen;
				pending_runs.push_back(r);
			end else if (sym == CH_ROW || sym == CH_END) begin
				run_count      = '0;
				r.run_length   = cells_left;
				r.row_end      = 1'b1;
				r.pattern_end  = (sym == CH_END);
				r.row_overflow = overflow_seen;
				pending_runs.push_back(r);
				cells_left    = row_width;
				overflow_seen = 1'b0;
			end
		endfunction

		function void check_run(result_t got);
			result_t exp;
			if (pending_runs.size() == 0) begin
				$error("unexpected run word: tdata %0d tlast %0b tuser %03b",
					got.run_length, got.row_end,
					{got.row_overflow, got.pattern_end, got.cell_value});
				errors++;
				return;
			end
			exp = pending_runs.pop_front();
			if (got.cell_value !== exp.cell_value) begin
				$error("cell_value: expected %0b, got %0b", exp.cell_value, got.cell_value);
				errors++;
			end
			if (got.run_length !== exp.run_length) begin
				$error("run_length: expected %0d, got %0d", exp.run_length, got.run_length);
				errors++;
			end
			if (got.row_end !== exp.row_end) begin
				$error("row_end: expected %0b, got %0b", exp.row_end, got.row_end);
				errors++;
			end
			if (got.pattern_end !== exp.pattern_end) begin
				$error("pattern_end: expected %0b, got %0b", exp.pattern_end, got.pattern_end);
				errors++;
			end
			if (got.row_overflow !== exp.row_overflow) begin
				$error("row_overflow: expected %0b, got %0b", exp.row_overflow,
					got.row_overflow);
				errors++;
			end
		endfunction
	endclass

	run_scoreboard sb = new();

	int send_idle_pct = 8;
	int recv_idle_pct = 69;
	int n_counted;
	int cycles;

	rle_cell_pattern_decoder_top #(
		.COUNT_BITS(COUNT_BITS)
	) i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tlast (m_axis_tlast),
		.m_axis_tuser (m_axis_tuser),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("rle_cell_pattern_decoder_top regression: fail");
			$finish;
		end
	end

	// result side: check accepted words, stall at random
	always @(posedge clk) begin
		result_t got;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got.cell_value   = m_axis_tuser[0];
			got.pattern_end  = m_axis_tuser[1];
			got.row_overflow = m_axis_tuser[2];
			got.row_end      = m_axis_tlast;
			got.run_length   = m_axis_tdata;
			sb.check_run(got);
		end
		m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
	end

	task automatic push_symbol(input logic [7:0] sym);
		// each cycle idles with the given odds
		while ($urandom_range(0, 99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= sym;
		do @(posedge clk); while (!s_axis_tready);
		sb.note_symbol(sym);
		if (classify(sym) != SYM_OTHER)
			n_counted++;
	endtask

	task automatic push_text(input string s);
		for (int i = 0; i < s.len(); i++)
			push_symbol(s[i]);
	endtask

	// mostly count + run char, some row/pattern closes, some noise bytes
	task automatic push_random_token();
		int r;
		int nd;
		r = $urandom_range(0, 99);
		if (r < 70) begin
			if ($urandom_range(0, 99) < 6) begin
				push_text($sformatf("%0d", sb.cells_left));
			end else begin
				nd = $urandom_range(0, 99);
				nd = (nd < 30) ? 0 : (nd < 70) ? 1 : (nd < 90) ? 2 : (nd < 96) ? 3 :
					$urandom_range(5, 6);
				repeat (nd) push_symbol(8'(CH_ZERO + $urandom_range(0, 9)));
			end
			push_symbol($urandom_range(0, 1) ? CH_LIVE : CH_DEAD);
		end else if (r < 82) begin
			push_symbol(($urandom_range(0, 3) == 0) ? CH_END : CH_ROW);
		end else begin
			push_symbol(8'($urandom_range(0, 255)));
		end
	endtask

	// digits give no word, so allow the pipe to settle after the last one
	task automatic drain();
		s_axis_tvalid <= 1'b0;
		while (sb.pending_runs.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_row_width(input logic [15:0] w);
		drain();
		cfg_valid <= 1'b1;
		cfg_data  <= w;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		sb.set_width(w);
	endtask

	task automatic run_phase(input logic [15:0] w, input int send_pct, input int recv_pct,
			input int n_items);
		int target;
		write_row_width(w);
		send_idle_pct = send_pct;
		recv_idle_pct = recv_pct;
		target = n_counted + n_items;
		while (n_counted < target)
			push_random_token();
	endtask

	initial begin
		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		m_axis_tready = 1'b0;
		cfg_valid     = 1'b0;
		cfg_data      = '0;
		cycles        = 0;
		n_counted     = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// directed: plain runs, saturated count, exact fill, ignored chars, zero count
		push_text("3o2b$");
		push_text("99999o");
		push_text("b!");
		push_text("64o$");
		push_text("1x2o");
		push_text("0b");
		push_symbol(8'h00);
		push_symbol(8'hff);
		push_symbol(CH_END);

		run_phase(16'd1, 8, 69, 200);
		run_phase(16'd13, 8, 69, 200);
		run_phase(16'hffff, 69, 8, 180);
		run_phase(16'd0, 69, 8, 60);
		run_phase(16'($urandom_range(2, 40)), 69, 8, 150);
		run_phase(16'($urandom_range(41, 300)), 0, 0, 180);
		run_phase(16'($urandom_range(1, 65535)), 0, 0, 150);
		drain();

		if (sb.pending_runs.size() != 0) begin
			$error("%0d run words never arrived", sb.pending_runs.size());
			sb.errors++;
		end
		if (sb.errors == 0)
			$display("rle_cell_pattern_decoder_top regression: pass");
		else
			$display("rle_cell_pattern_decoder_top regression: fail");
		$finish;
	end

endmodule

`default_nettype wire

// ===== filelist.f =====
+incdir+hdl
hdl/rcpd_pkg.sv
hdl/rcpd_core.sv
hdl/rcpd_out_reg.sv
hdl/rle_cell_pattern_decoder_top.sv
hdl/rcpd_checker.sv
test/rle_cell_pattern_decoder_top_tb.sv
